/* hdl/tls_sni_pkg.sv */
// Shared types and constants for the TLS ClientHello SNI extractor.
// No dependencies.
package tls_sni_pkg;
  localparam int MaxPeekSize = 16384;
  localparam int NameDepth = 256;

  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_EOD = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_RESTART = 2'd3;

  localparam logic [2:0] ST_SNI = 3'd0;
  localparam logic [2:0] ST_NOSNI = 3'd1;
  localparam logic [2:0] ST_MALF = 3'd2;
  localparam logic [2:0] ST_INCOMPLETE = 3'd3;
  localparam logic [2:0] ST_TOOBIG = 3'd4;
  localparam logic [2:0] ST_READ = 3'd5;
  localparam logic [2:0] ST_NONE = 3'd7;

  localparam logic [0:0] CFG_HOST_CAP = 1'd0;
  localparam logic [0:0] CFG_SCRATCH_CAP = 1'd1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [7:0] name_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [14:0] bytes_needed;
    logic [7:0]  hostname_length;
    logic [7:0]  name_byte;
  } out_item_t;

  // name store write request
  typedef struct packed {
    logic       we;
    logic [7:0] addr;
    logic [7:0] data;
  } store_wr_t;
endpackage

/* hdl/tls_sni_if.sv */
// Valid/ready stream interface carrying one payload word.
// No package dependency; the payload type is a parameter.
interface tls_sni_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/tls_sni_store.sv */
// Host name store: 256 x 8 synchronous RAM, one write and one registered read port.
// Depends on tls_sni_pkg.
module tls_sni_store #(
  parameter int NAME_DEPTH = tls_sni_pkg::NameDepth
) (
  input  logic                    clk,
  input  tls_sni_pkg::store_wr_t  wr,
  input  logic [7:0]              rd_addr,
  output logic [7:0]              rd_data
);
  import tls_sni_pkg::*;
  localparam int AW = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
  logic [7:0] mem [NAME_DEPTH];
  logic [AW-1:0] wa, ra;
  assign wa = AW'(wr.addr);
  assign ra = AW'(rd_addr);

  always_ff @(posedge clk) begin
    if (wr.we && (32'(wr.addr) < NAME_DEPTH)) mem[wa] <= wr.data;
    rd_data <= mem[ra];
  end
endmodule

/* hdl/tls_sni_parser.sv */
// Byte-serial record and ClientHello parser; produces at most one result per request.
// Depends on tls_sni_pkg; drives the name store write port.
module tls_sni_parser #(
  parameter int MAX_PEEK_SIZE = tls_sni_pkg::MaxPeekSize
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  tls_sni_pkg::in_item_t  item,
  input  logic [8:0]             host_cap,
  input  logic [14:0]            scratch_cap,
  output logic                   res_valid,
  output tls_sni_pkg::out_item_t res,
  output tls_sni_pkg::store_wr_t wr
);
  import tls_sni_pkg::*;

  localparam logic [4:0] B_FIX = 5'd0, B_SID = 5'd1, B_CSH = 5'd2, B_CSL = 5'd3,
    B_CS = 5'd4, B_CMLEN = 5'd5, B_CM = 5'd6, B_EXH = 5'd7, B_EXL = 5'd8,
    B_ETH = 5'd9, B_ETL = 5'd10, B_ELH = 5'd11, B_ELL = 5'd12, B_SKIP = 5'd13,
    B_LLH = 5'd14, B_LLL = 5'd15, B_NT = 5'd16, B_NLH = 5'd17, B_NLL = 5'd18,
    B_NAME = 5'd19, B_END = 5'd20;
  localparam logic [2:0] PH_PAYLOAD = 3'd5, PH_DONE = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [16:0] offset, offset_next;
  logic [15:0] rec_rem, rec_rem_next;
  logic [15:0] hs_cnt, hs_cnt_next;
  logic [24:0] exp_hs, exp_hs_next;
  logic [15:0] r0, r0_next, r1, r1_next, r2, r2_next;
  logic [7:0]  lab_len, lab_len_next, prev_c, prev_c_next;
  logic        f_sni, f_bad, f_over, f_hdr;
  logic        f_sni_next, f_bad_next, f_over_next, f_hdr_next;
  logic [2:0]  pend, pend_next;
  logic [4:0]  step, step_next;
  logic [7:0]  hs_kind, hs_kind_next;
  logic [8:0]  fill, fill_next;
  logic        known, known_next;
  logic        rv_next;
  out_item_t   res_next;

  logic [7:0]  b;
  logic [26:0] e, q;
  logic [26:0] v;
  logic [31:0] tmp;

  assign b = item.data_byte;
  assign e = 27'(exp_hs);

  function automatic logic host_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || c == "-";
  endfunction

  always_comb begin
    phase_next = phase; offset_next = offset; rec_rem_next = rec_rem;
    hs_cnt_next = hs_cnt; exp_hs_next = exp_hs; r0_next = r0; r1_next = r1;
    r2_next = r2; lab_len_next = lab_len; prev_c_next = prev_c;
    f_sni_next = f_sni; f_bad_next = f_bad; f_over_next = f_over; f_hdr_next = f_hdr;
    pend_next = pend; step_next = step; hs_kind_next = hs_kind; fill_next = fill;
    known_next = known;
    rv_next = 1'b0;
    res_next = '0;
    wr = '0;
    q = 27'(hs_cnt) + 27'd1;
    v = '0;
    tmp = '0;

    if (go) begin
      unique case (item.req_type)
        REQ_RESTART: begin
          phase_next = '0; offset_next = '0; rec_rem_next = '0; hs_cnt_next = '0;
          exp_hs_next = '0; r0_next = '0; r1_next = '0; r2_next = '0;
          lab_len_next = '0; prev_c_next = '0; f_sni_next = 1'b0; f_bad_next = 1'b0;
          f_over_next = 1'b0; f_hdr_next = 1'b0; pend_next = ST_NONE; step_next = B_FIX;
          hs_kind_next = '0; fill_next = '0; known_next = 1'b0;
        end
        REQ_READ: begin
          rv_next = 1'b1;
          res_next.status = ST_READ;
          res_next.hostname_length = (pend == ST_SNI) ? fill[7:0] : 8'd0;
        end
        REQ_EOD: begin
          rv_next = 1'b1;
          if (phase == PH_DONE) begin
            res_next.status = pend;
            res_next.hostname_length = (pend == ST_SNI) ? fill[7:0] : 8'd0;
          end else if (scratch_cap < 15'd4 || host_cap == 9'd0) begin
            res_next.status = ST_MALF; pend_next = ST_MALF; phase_next = PH_DONE;
          end else if (phase < PH_PAYLOAD) begin
            tmp = 32'(offset) - 32'(phase) + 32'd5;
            if (tmp > 32'(MAX_PEEK_SIZE)) begin
              res_next.status = ST_TOOBIG; pend_next = ST_TOOBIG; phase_next = PH_DONE;
            end else begin
              res_next.status = ST_INCOMPLETE; res_next.bytes_needed = tmp[14:0];
            end
          end else begin
            tmp = 32'(offset) + 32'(rec_rem);
            res_next.status = ST_INCOMPLETE; res_next.bytes_needed = tmp[14:0];
          end
        end
        default: begin
          if (phase == PH_DONE) begin
          end else if (scratch_cap < 15'd4 || host_cap == 9'd0) begin
            rv_next = 1'b1; res_next.status = ST_MALF;
            pend_next = ST_MALF; phase_next = PH_DONE;
          end else begin
            offset_next = offset + 17'd1;
            if (phase < PH_PAYLOAD) begin
              phase_next = phase + 3'd1;
              case (phase)
                3'd0: begin
                  f_over_next = 1'b0;
                  f_hdr_next = (b != 8'd22);
                end
                3'd1: if (b != 8'd3) f_hdr_next = 1'b1;
                3'd3: rec_rem_next = {b, 8'd0};
                3'd4: begin
                  tmp = 32'({rec_rem[15:8], b});
                  if (f_hdr || tmp == 0) begin
                    rv_next = 1'b1; res_next.status = ST_MALF;
                    pend_next = ST_MALF; phase_next = PH_DONE;
                  end else if (32'(offset_next) + tmp > 32'(MAX_PEEK_SIZE)) begin
                    rv_next = 1'b1; res_next.status = ST_TOOBIG;
                    pend_next = ST_TOOBIG; phase_next = PH_DONE;
                  end else begin
                    if (32'(hs_cnt) + tmp > 32'(scratch_cap)) f_over_next = 1'b1;
                    rec_rem_next = tmp[15:0];
                  end
                end
                default: ;
              endcase
            end else begin
              if (!f_over) begin
                hs_cnt_next = hs_cnt + 16'd1;
                if (hs_cnt == 16'd0) hs_kind_next = b;
                else if (hs_cnt == 16'd1) exp_hs_next = 25'(b);
                else if (hs_cnt == 16'd2) exp_hs_next = {exp_hs[16:0], b};
                else if (hs_cnt == 16'd3) begin
                  exp_hs_next = {exp_hs[16:0], b} + 25'd4;
                  if ({exp_hs[16:0], b} + 25'd4 < 25'd39) f_bad_next = 1'b1;
                end else if (27'(hs_cnt) < e && !f_bad) begin
                  case (step)
                    B_FIX: if (hs_cnt == 16'd38) begin
                      if (b > 8'd32 || 27'd41 + 27'(b) > e) f_bad_next = 1'b1;
                      else if (b == 8'd0) step_next = B_CSH;
                      else begin r0_next = 16'(b); step_next = B_SID; end
                    end
                    B_SID: begin
                      r0_next = r0 - 16'd1;
                      if (r0 == 16'd1) step_next = B_CSH;
                    end
                    B_CSH: begin r0_next = {b, 8'd0}; step_next = B_CSL; end
                    B_CSL: begin
                      v = 27'({r0[15:8], b});
                      if (v == 0 || v[0] || q + v + 27'd1 > e) f_bad_next = 1'b1;
                      else begin r0_next = v[15:0]; step_next = B_CS; end
                    end
                    B_CS: begin
                      r0_next = r0 - 16'd1;
                      if (r0 == 16'd1) step_next = B_CMLEN;
                    end
                    B_CMLEN: begin
                      if (b == 8'd0 || q + 27'(b) > e) f_bad_next = 1'b1;
                      else begin r0_next = 16'(b); step_next = B_CM; end
                    end
                    B_CM: begin
                      r0_next = r0 - 16'd1;
                      if (r0 == 16'd1) begin
                        if (q == e) step_next = B_END;
                        else if (q + 27'd1 == e) f_bad_next = 1'b1;
                        else step_next = B_EXH;
                      end
                    end
                    B_EXH: begin r0_next = {b, 8'd0}; step_next = B_EXL; end
                    B_EXL: begin
                      v = 27'({r0[15:8], b});
                      if (q + v != e) f_bad_next = 1'b1;
                      else if (q == e) step_next = B_END;
                      else if (q + 27'd4 > e) f_bad_next = 1'b1;
                      else step_next = B_ETH;
                    end
                    B_ETH: begin r0_next = {b, 8'd0}; step_next = B_ETL; end
                    B_ETL: begin r0_next = {r0[15:8], b}; step_next = B_ELH; end
                    B_ELH: begin r1_next = {b, 8'd0}; step_next = B_ELL; end
                    B_ELL: begin
                      v = 27'({r1[15:8], b});
                      if (q + v > e) f_bad_next = 1'b1;
                      else if (r0 == 16'd0) begin
                        if (f_sni || v < 27'd5) f_bad_next = 1'b1;
                        else begin
                          f_sni_next = 1'b1; r1_next = v[15:0]; step_next = B_LLH;
                        end
                      end else if (v == 0) begin
                        if (q == e) step_next = B_END;
                        else if (q + 27'd4 > e) f_bad_next = 1'b1;
                        else step_next = B_ETH;
                      end else begin r0_next = v[15:0]; step_next = B_SKIP; end
                    end
                    B_SKIP: begin
                      r0_next = r0 - 16'd1;
                      if (r0 == 16'd1) begin
                        if (q == e) step_next = B_END;
                        else if (q + 27'd4 > e) f_bad_next = 1'b1;
                        else step_next = B_ETH;
                      end
                    end
                    B_LLH: begin r0_next = {b, 8'd0}; step_next = B_LLL; end
                    B_LLL: begin
                      v = 27'({r0[15:8], b});
                      if (v + 27'd2 != 27'(r1)) f_bad_next = 1'b1;
                      else begin r1_next = v[15:0]; step_next = B_NT; end
                    end
                    B_NT: if (b != 8'd0) f_bad_next = 1'b1; else step_next = B_NLH;
                    B_NLH: begin r2_next = {b, 8'd0}; step_next = B_NLL; end
                    B_NLL: begin
                      v = 27'({r2[15:8], b});
                      if (v == 0 || v + 27'd3 > 27'(r1) || v > 27'd253 ||
                          v + 27'd1 > 27'(host_cap)) f_bad_next = 1'b1;
                      else begin
                        r2_next = v[15:0]; fill_next = '0; lab_len_next = '0;
                        prev_c_next = '0; step_next = B_NAME;
                      end
                    end
                    B_NAME: begin
                      if (b == ".") begin
                        if (lab_len == 0 || lab_len > 8'd63 || prev_c == "-") f_bad_next = 1'b1;
                        lab_len_next = '0;
                      end else if (!host_char(b) || (lab_len == 0 && b == "-")) begin
                        f_bad_next = 1'b1;
                      end else if (lab_len < 8'd255) lab_len_next = lab_len + 8'd1;
                      wr.we = 1'b1; wr.addr = fill[7:0]; wr.data = b;
                      fill_next = fill + 9'd1;
                      prev_c_next = b;
                      if (!f_bad_next && 16'(fill_next) == r2) begin
                        if (lab_len_next == 0 || lab_len_next > 8'd63 || b == "-")
                          f_bad_next = 1'b1;
                        else if (r2 + 16'd3 != r1) f_bad_next = 1'b1;
                        else if (q == e) step_next = B_END;
                        else if (q + 27'd4 > e) f_bad_next = 1'b1;
                        else step_next = B_ETH;
                      end
                    end
                    default: f_bad_next = 1'b1;
                  endcase
                end
              end
              rec_rem_next = rec_rem - 16'd1;
              if (rec_rem == 16'd1) begin
                phase_next = '0;
                if (f_over) begin
                  rv_next = 1'b1; res_next.status = ST_TOOBIG;
                end else begin
                  if (!known && hs_cnt_next >= 16'd4) begin
                    if (hs_kind_next != 8'd1) begin
                      rv_next = 1'b1; res_next.status = ST_MALF;
                    end else if (exp_hs_next > 25'(scratch_cap) ||
                                 exp_hs_next > 25'(MAX_PEEK_SIZE)) begin
                      rv_next = 1'b1; res_next.status = ST_TOOBIG;
                    end else known_next = 1'b1;
                  end
                  if (!rv_next && known_next && 25'(hs_cnt_next) >= exp_hs_next) begin
                    rv_next = 1'b1;
                    if (f_bad_next || step_next != B_END) res_next.status = ST_MALF;
                    else if (f_sni_next) begin
                      res_next.status = ST_SNI;
                      res_next.hostname_length = fill_next[7:0];
                    end else res_next.status = ST_NOSNI;
                  end
                end
                if (rv_next) begin
                  pend_next = res_next.status; phase_next = PH_DONE;
                end
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0; offset <= '0; rec_rem <= '0; hs_cnt <= '0; exp_hs <= '0;
      r0 <= '0; r1 <= '0; r2 <= '0; lab_len <= '0; prev_c <= '0;
      f_sni <= 1'b0; f_bad <= 1'b0; f_over <= 1'b0; f_hdr <= 1'b0;
      pend <= ST_NONE; step <= B_FIX; hs_kind <= '0; fill <= '0; known <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      phase <= phase_next; offset <= offset_next; rec_rem <= rec_rem_next;
      hs_cnt <= hs_cnt_next; exp_hs <= exp_hs_next; r0 <= r0_next; r1 <= r1_next;
      r2 <= r2_next; lab_len <= lab_len_next; prev_c <= prev_c_next;
      f_sni <= f_sni_next; f_bad <= f_bad_next; f_over <= f_over_next; f_hdr <= f_hdr_next;
      pend <= pend_next; step <= step_next; hs_kind <= hs_kind_next; fill <= fill_next;
      known <= known_next; res_valid <= rv_next;
    end
    res <= res_next;
  end
endmodule

/* hdl/tls_client_hello_sni_extractor_unit.sv */
// TLS ClientHello SNI extractor: top level.
// Uses tls_sni_pkg, tls_sni_if, tls_sni_parser and tls_sni_store.
//
// Requests arrive on in_ch (req_type, data_byte, name_index); results leave
// on out_ch. Stream bytes advance the record/handshake parser; a result is
// produced for record errors, for the record completing the handshake, for
// end-of-data and for every host name read. Restart clears parse state.
// Configuration: cfg_we/cfg_index/cfg_data, index 0 host name capacity,
// index 1 scratch capacity; write only while idle.
// Throughput: one request per cycle while in_ch.ready is high. A result passes
// the parser register, the name RAM read register and then the result queue
// before it is offered on out_ch.
// A four-entry queue holds results while out_ch is stalled; in_ch.ready
// drops while four results are in flight, so nothing is lost.
// Reset (rst, synchronous) returns capacities to 256 and 16384 and the
// parser to its first header byte; the name RAM is not cleared, only
// entries below the stored length are ever returned.
module tls_client_hello_sni_extractor_unit #(
  parameter int MAX_PEEK_SIZE = tls_sni_pkg::MaxPeekSize,
  parameter int NAME_DEPTH = tls_sni_pkg::NameDepth
) (
  input  logic        clk,
  input  logic        rst,
  tls_sni_if.sink     in_ch,
  tls_sni_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [14:0] cfg_data
);
  import tls_sni_pkg::*;

  logic [8:0]  host_cap;
  logic [14:0] scratch_cap;
  logic        go;
  in_item_t    it;
  logic        p_valid;
  out_item_t   p_res;
  store_wr_t   wr;
  logic [7:0]  rd_data;
  logic [7:0]  idx_q;
  logic        s2_valid;
  out_item_t   s2;
  out_item_t   q_mem [4];
  logic [2:0]  q_cnt;
  logic [1:0]  q_wp, q_rp;
  logic [2:0]  inflight;

  assign it = in_ch.data;
  // slots reserved: queue plus two pipeline stages
  assign inflight = q_cnt + 3'(p_valid) + 3'(s2_valid);
  assign in_ch.ready = (inflight < 3'd4);
  assign go = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      host_cap <= 9'd256; scratch_cap <= 15'd16384;
    end else if (cfg_we) begin
      if (cfg_index == CFG_HOST_CAP) host_cap <= cfg_data[8:0];
      else if (cfg_index == CFG_SCRATCH_CAP) scratch_cap <= cfg_data;
    end
  end

  tls_sni_parser #(.MAX_PEEK_SIZE(MAX_PEEK_SIZE)) u_parser (
    .clk, .rst, .go, .item(it), .host_cap, .scratch_cap,
    .res_valid(p_valid), .res(p_res), .wr
  );

  always_ff @(posedge clk) if (go) idx_q <= it.name_index;

  tls_sni_store #(.NAME_DEPTH(NAME_DEPTH)) u_store (
    .clk, .wr, .rd_addr(idx_q), .rd_data
  );

  logic [7:0] idx_s2;
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else s2_valid <= p_valid;
    s2 <= p_res;
    idx_s2 <= idx_q;
  end

  out_item_t s2_full;
  always_comb begin
    s2_full = s2;
    if (s2.status == ST_READ && idx_s2 < s2.hostname_length) s2_full.name_byte = rd_data;
  end

  logic push, pop;
  assign pop = out_ch.valid && out_ch.ready;
  assign push = s2_valid;
  assign out_ch.valid = q_cnt != 3'd0;
  assign out_ch.data = q_mem[q_rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0; q_wp <= '0; q_rp <= '0;
    end else begin
      if (push) q_wp <= q_wp + 2'd1;
      if (pop) q_rp <= q_rp + 2'd1;
      q_cnt <= q_cnt + 3'(push) - 3'(pop);
    end
    if (push) q_mem[q_wp] <= s2_full;
  end
endmodule

/* tb/sv/tls_sni_checker.sv */
// Checker for the TLS ClientHello SNI extractor: watches both channels and the
// configuration port, predicts every result and compares field by field.
// Depends on tls_sni_pkg and tls_sni_if.
module tls_sni_checker (
  input  logic        clk,
  input  logic        rst,
  tls_sni_if          in_ch,
  tls_sni_if          out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [14:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          accepted,
  output int          results,
  output int          sni_found
);
  import tls_sni_pkg::*;

  localparam int unsigned PH_PAYLOAD = 5;
  localparam int unsigned PH_DONE = 6;
  localparam int unsigned F_SNI = 1;
  localparam int unsigned F_BODYBAD = 2;
  localparam int unsigned F_OVER = 4;
  localparam int unsigned F_HDRBAD = 8;

  typedef enum int {
    B_FIX, B_SID, B_CSH, B_CSL, B_CS, B_CMLEN, B_CM, B_EXH, B_EXL, B_ETH, B_ETL,
    B_ELH, B_ELL, B_SKIP, B_LLH, B_LLL, B_NT, B_NLH, B_NLL, B_NAME, B_END
  } body_step_e;

  int unsigned host_cap, scratch_cap;
  int unsigned phase, offset, rec_left, hs_count, hs_len, label_len, last_char;
  int unsigned flags, verdict, hs_kind, name_fill;
  int unsigned fld [3];
  bit          hs_known;
  body_step_e  step;
  logic [7:0]  name_mem [256];
  out_item_t   verdict_q [$];

  function automatic void clear_parse();
    phase = 0; offset = 0; rec_left = 0; hs_count = 0; hs_len = 0;
    fld[0] = 0; fld[1] = 0; fld[2] = 0;
    label_len = 0; last_char = 0; flags = 0; verdict = ST_NONE;
    step = B_FIX; hs_kind = 0; name_fill = 0; hs_known = 0;
  endfunction

  function automatic void body_bad();
    flags |= F_BODYBAD;
  endfunction

  function automatic void next_ext(int unsigned q);
    if (q == hs_len) step = B_END;
    else if (q + 4 > hs_len) body_bad();
    else step = B_ETH;
  endfunction

  function automatic bit host_char(int unsigned c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || c == "-";
  endfunction

  function automatic void take_name_char(int unsigned b);
    if (b == ".") begin
      if (label_len == 0 || label_len > 63 || last_char == "-") body_bad();
      label_len = 0;
    end else if (!host_char(b) || (label_len == 0 && b == "-")) begin
      body_bad();
    end else if (label_len < 255) begin
      label_len++;
    end
    if (name_fill < 256) name_mem[name_fill] = b[7:0];
    name_fill++;
    last_char = b;
  endfunction

  function automatic void hello_body_byte(int unsigned h, int unsigned b);
    int unsigned q, v;
    q = h + 1;
    case (step)
      B_FIX: if (h == 38) begin
        if (b > 32 || 41 + b > hs_len) body_bad();
        else if (b == 0) step = B_CSH;
        else begin fld[0] = b; step = B_SID; end
      end
      B_SID: begin fld[0]--; if (fld[0] == 0) step = B_CSH; end
      B_CSH: begin fld[0] = b << 8; step = B_CSL; end
      B_CSL: begin
        v = fld[0] | b;
        if (v == 0 || v[0] || q + v + 1 > hs_len) body_bad();
        else begin fld[0] = v; step = B_CS; end
      end
      B_CS: begin fld[0]--; if (fld[0] == 0) step = B_CMLEN; end
      B_CMLEN: begin
        if (b == 0 || q + b > hs_len) body_bad();
        else begin fld[0] = b; step = B_CM; end
      end
      B_CM: begin
        fld[0]--;
        if (fld[0] == 0) begin
          if (q == hs_len) step = B_END;
          else if (q + 1 == hs_len) body_bad();
          else step = B_EXH;
        end
      end
      B_EXH: begin fld[0] = b << 8; step = B_EXL; end
      B_EXL: begin
        v = fld[0] | b;
        if (q + v != hs_len) body_bad(); else next_ext(q);
      end
      B_ETH: begin fld[0] = b << 8; step = B_ETL; end
      B_ETL: begin fld[0] |= b; step = B_ELH; end
      B_ELH: begin fld[1] = b << 8; step = B_ELL; end
      B_ELL: begin
        v = fld[1] | b;
        if (q + v > hs_len) body_bad();
        else if (fld[0] == 0) begin
          if ((flags & F_SNI) != 0 || v < 5) body_bad();
          else begin flags |= F_SNI; fld[1] = v; step = B_LLH; end
        end else if (v == 0) next_ext(q);
        else begin fld[0] = v; step = B_SKIP; end
      end
      B_SKIP: begin fld[0]--; if (fld[0] == 0) next_ext(q); end
      B_LLH: begin fld[0] = b << 8; step = B_LLL; end
      B_LLL: begin
        v = fld[0] | b;
        if (v + 2 != fld[1]) body_bad(); else begin fld[1] = v; step = B_NT; end
      end
      B_NT: if (b != 0) body_bad(); else step = B_NLH;
      B_NLH: begin fld[2] = b << 8; step = B_NLL; end
      B_NLL: begin
        v = fld[2] | b;
        if (v == 0 || v + 3 > fld[1] || v > 253 || v + 1 > host_cap) body_bad();
        else begin
          fld[2] = v; name_fill = 0; label_len = 0; last_char = 0; step = B_NAME;
        end
      end
      B_NAME: begin
        take_name_char(b);
        if ((flags & F_BODYBAD) == 0 && name_fill == fld[2]) begin
          if (label_len == 0 || label_len > 63 || last_char == "-") body_bad();
          else if (fld[2] + 3 != fld[1]) body_bad();
          else next_ext(q);
        end
      end
      default: body_bad();
    endcase
  endfunction

  function automatic void handshake_byte(int unsigned h, int unsigned b);
    if (h == 0) hs_kind = b;
    else if (h == 1) hs_len = b;
    else if (h == 2) hs_len = (hs_len << 8) | b;
    else if (h == 3) begin
      hs_len = ((hs_len << 8) | b) + 4;
      if (hs_len < 39) body_bad();
    end else if (h < hs_len && (flags & F_BODYBAD) == 0) begin
      hello_body_byte(h, b);
    end
  endfunction

  function automatic out_item_t conclude(int unsigned v);
    out_item_t r;
    verdict = v;
    phase = PH_DONE;
    r.status = v[2:0];
    r.bytes_needed = '0;
    r.hostname_length = (v == ST_SNI) ? name_fill[7:0] : 8'd0;
    r.name_byte = '0;
    return r;
  endfunction

  function automatic bit regs_bad();
    return scratch_cap < 4 || host_cap == 0;
  endfunction

  function automatic bit record_done(output out_item_t r);
    if ((flags & F_OVER) != 0) begin r = conclude(ST_TOOBIG); return 1; end
    if (!hs_known && hs_count >= 4) begin
      if (hs_kind != 1) begin r = conclude(ST_MALF); return 1; end
      if (hs_len > scratch_cap || hs_len > MaxPeekSize) begin
        r = conclude(ST_TOOBIG); return 1;
      end
      hs_known = 1;
    end
    if (hs_known && hs_count >= hs_len) begin
      if ((flags & F_BODYBAD) != 0 || step != B_END) r = conclude(ST_MALF);
      else r = conclude((flags & F_SNI) != 0 ? ST_SNI : ST_NOSNI);
      return 1;
    end
    phase = 0;
    return 0;
  endfunction

  function automatic bit take_stream_byte(int unsigned b, output out_item_t r);
    int unsigned len;
    if (phase == PH_DONE) return 0;
    if (regs_bad()) begin r = conclude(ST_MALF); return 1; end
    offset++;
    if (phase < PH_PAYLOAD) begin
      if (phase == 0) begin
        flags &= ~(F_HDRBAD | F_OVER);
        if (b != 22) flags |= F_HDRBAD;
      end else if (phase == 1) begin
        if (b != 3) flags |= F_HDRBAD;
      end else if (phase == 3) begin
        rec_left = b << 8;
      end else if (phase == 4) begin
        len = rec_left | b;
        if ((flags & F_HDRBAD) != 0 || len == 0) begin r = conclude(ST_MALF); return 1; end
        if (offset + len > MaxPeekSize) begin r = conclude(ST_TOOBIG); return 1; end
        if (hs_count + len > scratch_cap) flags |= F_OVER;
        rec_left = len;
      end
      phase++;
      return 0;
    end
    if ((flags & F_OVER) == 0) begin
      handshake_byte(hs_count, b);
      hs_count++;
    end
    rec_left--;
    if (rec_left == 0) return record_done(r);
    return 0;
  endfunction

  function automatic out_item_t data_end();
    out_item_t r;
    int unsigned need;
    if (phase == PH_DONE) begin
      r = '0;
      r.status = verdict[2:0];
      r.hostname_length = (verdict == ST_SNI) ? name_fill[7:0] : 8'd0;
      return r;
    end
    if (regs_bad()) return conclude(ST_MALF);
    if (phase < PH_PAYLOAD) begin
      need = offset - phase + 5;
      if (need > MaxPeekSize) return conclude(ST_TOOBIG);
    end else begin
      need = offset + rec_left;
    end
    r = '0;
    r.status = ST_INCOMPLETE;
    r.bytes_needed = need[14:0];
    return r;
  endfunction

  function automatic bit predict_result(in_item_t it, output out_item_t r);
    int unsigned len;
    r = '0;
    case (it.req_type)
      REQ_RESTART: begin clear_parse(); return 0; end
      REQ_READ: begin
        len = (verdict == ST_SNI) ? name_fill : 0;
        r.status = ST_READ;
        r.hostname_length = len[7:0];
        r.name_byte = (it.name_index < len) ? name_mem[it.name_index] : 8'd0;
        return 1;
      end
      REQ_EOD: begin r = data_end(); return 1; end
      default: return take_stream_byte(it.data_byte, r);
    endcase
  endfunction

  always @(posedge clk) begin
    in_item_t  req;
    out_item_t got, want;
    if (rst) begin
      host_cap = 256;
      scratch_cap = 16384;
      foreach (name_mem[i]) name_mem[i] = '0;
      clear_parse();
      verdict_q.delete();
      errors = 0; accepted = 0; results = 0; sni_found = 0; pending = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_HOST_CAP) host_cap = cfg_data[8:0];
        else scratch_cap = cfg_data;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        results++;
        if (verdict_q.size() == 0) begin
          $error("result with nothing expected: status %0d", got.status);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (got.status == ST_SNI) sni_found++;
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
          if (got.bytes_needed !== want.bytes_needed) begin
            $error("bytes_needed: expected %0d, got %0d",
                   want.bytes_needed, got.bytes_needed);
            errors++;
          end
          if (got.hostname_length !== want.hostname_length) begin
            $error("hostname_length: expected %0d, got %0d",
                   want.hostname_length, got.hostname_length);
            errors++;
          end
          if (got.name_byte !== want.name_byte) begin
            $error("name_byte: expected %0d, got %0d", want.name_byte, got.name_byte);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        req = in_ch.data;
        accepted++;
        if (predict_result(req, want)) verdict_q.push_back(want);
      end
      pending = verdict_q.size();
    end
  end
endmodule

/* tb/sv/tls_client_hello_sni_extractor_unit_tb.sv */
// Testbench top for the TLS ClientHello SNI extractor: builds record streams
// carrying ClientHellos (good, truncated and damaged), drives them with idle
// and stall phases and register changes. Uses tls_sni_pkg, tls_sni_if, tls_sni_checker.
module tls_client_hello_sni_extractor_unit_tb;
  import tls_sni_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int ItemTarget = 1300;
  // roughly half a session, so a phase does not overshoot its share by much
  localparam int SessionMargin = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_HOST_CAP;
  logic [14:0] cfg_data = '0;
  int          errors, pending, accepted, results, sni_found;
  int          cycles = 0;
  int          sent = 0;
  int          idle_pct = 0, stall_pct = 0;
  bit          hold_req = 0;
  byte unsigned hs [$];
  byte unsigned strm [$];
  byte unsigned host [$];

  tls_sni_if #(.payload_t(in_item_t))  in_ch (clk);
  tls_sni_if #(.payload_t(out_item_t)) out_ch (clk);

  tls_client_hello_sni_extractor_unit u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tls_sni_checker u_chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .accepted(accepted),
    .results(results), .sni_found(sni_found)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off that fills the block
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = 300;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(logic [1:0] kind, byte unsigned b, byte unsigned idx);
    in_item_t it;
    int       seen;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    it.req_type = kind;
    it.data_byte = b;
    it.name_index = idx;
    in_ch.data = it;
    in_ch.valid = 1'b1;
    seen = accepted;
    do @(negedge clk); while (accepted == seen);
    sent++;
  endtask

  task automatic send_bytes(byte unsigned bytes [$]);
    foreach (bytes[i]) send(REQ_BYTE, bytes[i], 8'($urandom));
  endtask

  task automatic write_reg(logic [0:0] idx, int unsigned val);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_index = idx;
    cfg_data = val[14:0];
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic byte unsigned name_char(bit edge_pos);
    string alnum;
    int    k;
    alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    k = $urandom_range(0, alnum.len());
    if (k == alnum.len()) return edge_pos ? "x" : "-";
    return alnum[k];
  endfunction

  task automatic make_host();
    int nlab, llen;
    bit longname;
    host.delete();
    longname = ($urandom_range(0, 15) == 0);
    nlab = longname ? 4 : $urandom_range(1, 3);
    for (int l = 0; l < nlab; l++) begin
      if (l > 0) host.push_back(".");
      if (longname) llen = (l == 3) ? $urandom_range(57, 61) : $urandom_range(62, 64);
      else llen = $urandom_range(1, 8);
      for (int c = 0; c < llen; c++) host.push_back(name_char(c == 0 || c == llen - 1));
    end
  endtask

  // handshake message: ClientHello with random content, optional server_name
  task automatic make_hello(bit with_sni, bit damage);
    byte unsigned body [$];
    byte unsigned ext [$];
    int           n, len;
    body = {8'd3, 8'd3};
    repeat (32) body.push_back(8'($urandom));
    n = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(0, 3);
    body.push_back(8'(n));
    repeat (n) body.push_back(8'($urandom));
    n = $urandom_range(1, 3);
    body.push_back(8'd0);
    body.push_back(8'(2 * n));
    repeat (2 * n) body.push_back(8'($urandom));
    n = $urandom_range(1, 2);
    body.push_back(8'(n));
    repeat (n) body.push_back(8'($urandom));
    if ($urandom_range(0, 5) != 0) begin
      repeat ($urandom_range(0, 2)) begin
        n = $urandom_range(0, 4);
        ext.push_back(8'($urandom));
        ext.push_back(8'($urandom_range(1, 255)));
        ext.push_back(8'd0);
        ext.push_back(8'(n));
        repeat (n) ext.push_back(8'($urandom));
      end
      if (with_sni) begin
        make_host();
        len = host.size();
        ext.push_back(8'd0); ext.push_back(8'd0);
        ext.push_back(8'((len + 5) >> 8)); ext.push_back(8'(len + 5));
        ext.push_back(8'((len + 3) >> 8)); ext.push_back(8'(len + 3));
        ext.push_back(8'd0);
        ext.push_back(8'(len >> 8)); ext.push_back(8'(len));
        foreach (host[i]) ext.push_back(host[i]);
      end
      if ($urandom_range(0, 2) == 0) begin
        ext.push_back(8'd0); ext.push_back(8'd23); ext.push_back(8'd0); ext.push_back(8'd0);
      end
      body.push_back(8'(ext.size() >> 8));
      body.push_back(8'(ext.size()));
      foreach (ext[i]) body.push_back(ext[i]);
    end
    len = body.size();
    hs = {8'd1, 8'd0, 8'(len >> 8), 8'(len)};
    foreach (body[i]) hs.push_back(body[i]);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 5)) hs.push_back(8'($urandom));
    if (damage) hs[$urandom_range(0, hs.size() - 1)] ^= 8'($urandom_range(1, 255));
  endtask

  // split the handshake into records
  task automatic make_records();
    int at, chunk;
    strm.delete();
    at = 0;
    while (at < hs.size()) begin
      chunk = ($urandom_range(0, 2) == 0) ? hs.size() - at : $urandom_range(1, 40);
      if (chunk > hs.size() - at) chunk = hs.size() - at;
      strm.push_back(8'd22);
      strm.push_back(8'd3);
      strm.push_back(8'($urandom_range(0, 3)));
      strm.push_back(8'(chunk >> 8));
      strm.push_back(8'(chunk));
      if ($urandom_range(0, 24) == 0) strm[strm.size() - $urandom_range(1, 5)] = 8'($urandom);
      for (int i = 0; i < chunk; i++) strm.push_back(hs[at + i]);
      at += chunk;
    end
  endtask

  task automatic run_session();
    int cut;
    make_hello($urandom_range(0, 4) != 0, $urandom_range(0, 7) == 0);
    make_records();
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, strm.size() - 1) : strm.size();
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 39) == 0) send(REQ_EOD, 8'($urandom), 8'($urandom));
      send(REQ_BYTE, strm[i], 8'($urandom));
    end
    send(REQ_EOD, 8'($urandom), 8'($urandom));
    for (int i = 0; i <= host.size() + 1 && i < 256; i++)
      send(REQ_READ, 8'($urandom), 8'(i));
    send(REQ_READ, 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 4))
        send(2'($urandom_range(0, 2)), 8'($urandom), 8'($urandom));
    send(REQ_RESTART, 8'($urandom), 8'($urandom));
  endtask

  initial begin
    in_item_t blank;
    blank = '0;
    in_ch.valid = 1'b0;
    in_ch.data = blank;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed: reads before any verdict, header errors, peek limit, partial header, wrong handshake type
    send(REQ_READ, 0, 8'hFF);
    send_bytes({8'd23, 8'd3, 8'd1, 8'd0, 8'd5});
    send(REQ_EOD, 0, 0);
    send(REQ_RESTART, 0, 0);
    send_bytes({8'd22, 8'd2, 8'd1, 8'd0, 8'd5});
    send(REQ_RESTART, 0, 0);
    send_bytes({8'd22, 8'd3, 8'd1, 8'd0, 8'd0});
    send(REQ_RESTART, 0, 0);
    send_bytes({8'd22, 8'd3, 8'd3, 8'hFF, 8'hFF});
    send(REQ_RESTART, 0, 0);
    send_bytes({8'd22, 8'd3});
    send(REQ_EOD, 0, 0);
    send_bytes({8'd1, 8'd0, 8'd4, 8'd2, 8'd0, 8'd0, 8'd0});
    send(REQ_EOD, 0, 0);
    send(REQ_RESTART, 0, 0);

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 77; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 77; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      case (p)
        1: begin write_reg(CFG_HOST_CAP, 1); write_reg(CFG_SCRATCH_CAP, 16384); end
        2: begin write_reg(CFG_HOST_CAP, 256); write_reg(CFG_SCRATCH_CAP, 0); end
        3: begin
          write_reg(CFG_HOST_CAP, $urandom_range(8, 40));
          write_reg(CFG_SCRATCH_CAP, 3);
        end
        4: begin write_reg(CFG_HOST_CAP, 256); write_reg(CFG_SCRATCH_CAP, $urandom_range(40, 120)); end
        5: begin write_reg(CFG_HOST_CAP, 0); write_reg(CFG_SCRATCH_CAP, 16384); end
        6: begin write_reg(CFG_HOST_CAP, 254); write_reg(CFG_SCRATCH_CAP, 32767); end
        7: begin write_reg(CFG_HOST_CAP, 511); write_reg(CFG_SCRATCH_CAP, 16384); end
        default: ;
      endcase
      send(REQ_RESTART, 0, 0);
      if (p == 0) begin
        run_session();
        hold_req = 1;
      end
      while (sent + SessionMargin < (p + 1) * ItemTarget / 8) run_session();
      // hold the sender until every result is back
      in_ch.valid = 1'b0;
      while (pending != 0) @(negedge clk);
    end

    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Ran %0d requests over 8 register settings and idle mixes;", sent);
    $display("checked %0d results, %0d with a server name found.", results, sni_found);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
